// File: sv/rss_pkg.sv
`default_nettype none

package rss_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int GRP_SIZE    = 8;
  localparam int NUM_GRPS    = (STACK_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
  localparam int NUM_SLOTS   = NUM_GRPS * GRP_SIZE;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic signed [31:0] code;
    logic [7:0]         age;
  } rec_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic cmp;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] item_code;
    logic [7:0]         item_age;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_code;
    logic [7:0]         out_age;
    logic [6:0]         depth_now;
    logic               is_empty;
    logic [6:0]         even_ages;
    logic [6:0]         odd_ages;
  } out_t;

endpackage

`default_nettype wire

// File: sv/rss_cell.sv
`default_nettype none

module rss_cell import rss_pkg::*; (
  input  wire logic               clk,
  input  wire cell_ctl_t          ctl,
  input  wire rec_t               above,
  input  wire rec_t               below,
  input  wire logic signed [31:0] key,
  input  wire logic               in_use,
  output rec_t                    rec,
  output logic                    hit
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      rec <= above;
    end else if (ctl.pop) begin
      rec <= below;
    end
    if (ctl.cmp) begin
      hit <= in_use && (rec.code == key);
    end
  end

endmodule

`default_nettype wire

// File: sv/rss_group.sv
`default_nettype none

module rss_group import rss_pkg::*; (
  input  wire logic                      clk,
  input  wire rec_t [GRP_SIZE-1:0]       recs,
  input  wire logic [GRP_SIZE-1:0]       hits,
  output rec_t                           pick,
  output logic                           any
);

  rec_t sel_rec;
  logic sel_hit;

  // lowest index is nearest the top
  always_comb begin
    sel_rec = '0;
    sel_hit = 1'b0;
    for (int i = GRP_SIZE - 1; i >= 0; i--) begin
      if (hits[i]) begin
        sel_rec = recs[i];
        sel_hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pick <= sel_rec;
    any  <= sel_hit;
  end

endmodule

`default_nettype wire

// File: sv/searchable_record_stack_top.sv
`default_nettype none

// push, pop, clear and a search on an empty stack: result in the cycle after the transfer, one item per
// cycle while the output is accepted; search on a nonempty stack: the result passes the cell compare,
// group pick and final pick stages in turn, and no new item is taken until it is registered
// a new item is taken whenever the block is idle and the output register is free
// or being emptied; rst (synchronous) empties the stack and clears the age counts

module searchable_record_stack_top import rss_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  typedef enum logic [1:0] {S_IDLE, S_GRP, S_FIN} state_t;

  state_t           state;
  logic [LVL_W-1:0] fill_level;
  logic [LVL_W-1:0] even_tally;
  logic [LVL_W-1:0] odd_tally;
  logic [LVL_W-1:0] fill_next;
  logic [LVL_W-1:0] even_next;
  logic [LVL_W-1:0] odd_next;
  logic [1:0]       status_next;
  rec_t             rec_next;
  logic             go_search;
  logic             in_xfer;
  logic             is_full;
  logic             is_none;
  cell_ctl_t        ctl;
  rec_t             push_rec;

  rec_t [NUM_SLOTS-1:0] slot_rec;
  logic [NUM_SLOTS-1:0] slot_hit;
  rec_t [NUM_GRPS-1:0]  grp_rec;
  logic [NUM_GRPS-1:0]  grp_hit;
  rec_t                 fin_rec;
  logic                 fin_hit;

  function automatic out_t make_out(input logic [1:0] st, input rec_t r,
                                    input logic [LVL_W-1:0] lvl,
                                    input logic [LVL_W-1:0] ev,
                                    input logic [LVL_W-1:0] od);
    out_t o;
    o.status    = st;
    o.out_code  = r.code;
    o.out_age   = r.age;
    o.depth_now = 7'(lvl);
    o.is_empty  = (lvl == '0);
    o.even_ages = 7'(ev);
    o.odd_ages  = 7'(od);
    return o;
  endfunction

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_xfer  = in_valid && in_ready;
  assign is_full  = (fill_level == LVL_W'(STACK_DEPTH));
  assign is_none  = (fill_level == '0);
  assign push_rec = '{code: in_data.item_code, age: in_data.item_age};

  // cell chain, slot 0 is the top
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
    if (i < STACK_DEPTH) begin : g_cell
      localparam int UP = (i == 0) ? 0 : i - 1;
      localparam int DN = (i + 1 < STACK_DEPTH) ? i + 1 : i;
      rss_cell u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .above  ((i == 0) ? push_rec : slot_rec[UP]),
        .below  (slot_rec[DN]),
        .key    (in_data.item_code),
        .in_use (LVL_W'(i) < fill_level),
        .rec    (slot_rec[i]),
        .hit    (slot_hit[i])
      );
    end else begin : g_pad
      assign slot_rec[i] = '0;
      assign slot_hit[i] = 1'b0;
    end
  end

  for (genvar g = 0; g < NUM_GRPS; g++) begin : g_grp
    rss_group u_group (
      .clk  (clk),
      .recs (slot_rec[g*GRP_SIZE +: GRP_SIZE]),
      .hits (slot_hit[g*GRP_SIZE +: GRP_SIZE]),
      .pick (grp_rec[g]),
      .any  (grp_hit[g])
    );
  end

  always_comb begin
    fin_rec = '0;
    fin_hit = 1'b0;
    for (int g = NUM_GRPS - 1; g >= 0; g--) begin
      if (grp_hit[g]) begin
        fin_rec = grp_rec[g];
        fin_hit = 1'b1;
      end
    end
  end

  always_comb begin
    fill_next   = fill_level;
    even_next   = even_tally;
    odd_next    = odd_tally;
    status_next = ST_OK;
    rec_next    = '0;
    go_search   = 1'b0;
    ctl         = '0;
    if (in_xfer) begin
      case (in_data.op)
        OP_PUSH: begin
          if (is_full) begin
            status_next = ST_FULL;
          end else begin
            ctl.push  = 1'b1;
            fill_next = fill_level + 1'b1;
            if (in_data.item_age[0]) begin
              odd_next = odd_tally + 1'b1;
            end else begin
              even_next = even_tally + 1'b1;
            end
          end
        end
        OP_POP: begin
          if (is_none) begin
            status_next = ST_EMPTY;
          end else begin
            ctl.pop   = 1'b1;
            fill_next = fill_level - 1'b1;
            rec_next  = slot_rec[0];
            if (slot_rec[0].age[0]) begin
              odd_next = odd_tally - 1'b1;
            end else begin
              even_next = even_tally - 1'b1;
            end
          end
        end
        OP_SEARCH: begin
          ctl.cmp = 1'b1;
          if (is_none) begin
            status_next = ST_EMPTY;
          end else begin
            go_search = 1'b1;
          end
        end
        OP_CLEAR: begin
          fill_next = '0;
          even_next = '0;
          odd_next  = '0;
        end
        default: begin
          status_next = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      fill_level <= '0;
      even_tally <= '0;
      odd_tally  <= '0;
    end else begin
      if (out_valid && out_ready && !in_xfer) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            fill_level <= fill_next;
            even_tally <= even_next;
            odd_tally  <= odd_next;
            if (go_search) begin
              state     <= S_GRP;
              out_valid <= 1'b0;
            end else begin
              out_valid <= 1'b1;
              out_data  <= make_out(status_next, rec_next, fill_next, even_next, odd_next);
            end
          end
        end
        S_GRP: begin
          state <= S_FIN;
        end
        S_FIN: begin
          out_valid <= 1'b1;
          out_data  <= make_out(fin_hit ? ST_OK : ST_MISSING, fin_hit ? fin_rec : '0,
                                fill_level, even_tally, odd_tally);
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // age counts always add up to the fill level
  assert property (@(posedge clk) disable iff (rst)
    ({1'b0, even_tally} + {1'b0, odd_tally}) == {1'b0, fill_level})
    else $error("age counts disagree with fill level");

  // a search on a nonempty stack holds out_valid low through the group and final pick states, then answers
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (in_data.op == OP_SEARCH) && !is_none)
    |=> !out_valid ##1 !out_valid ##1 out_valid)
    else $error("search result timing broken");

  // every other transfer answers in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !((in_data.op == OP_SEARCH) && !is_none)) |=> out_valid)
    else $error("missing result after transfer");

endmodule

`default_nettype wire
